// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL. In synthesis builds they expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_PROP_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_PROP_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: rtl/core/ptgm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ptgm_pkg;

   localparam int GRID_SIZE_DEF = 96;
   localparam int CPM_DEF       = 10;

   localparam int FUNC_W       = 2;
   localparam int CELL_INDEX_W = 14;
   localparam int COORD_W      = 16;
   localparam int VALUE_W      = 8;
   localparam int ROWS_W       = 7;
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 32;

   // Shared multiplier operand and product widths.
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 18;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Rounding of the scaled Q.22 coordinate to a cell number.
   localparam int RND_W      = 41;
   localparam int RND_SHIFT  = 22;
   localparam int CELL_W     = RND_W - RND_SHIFT;
   localparam int POSE_SHIFT = 14;

   localparam logic [FUNC_W-1:0] FUNC_MARK = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MARK_MUL,
      ST_MARK_ROW,
      ST_READ_DIV,
      ST_READ_MEM,
      ST_RESULT
   } ptgm_state_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] cos_heading;
      logic signed [COORD_W-1:0] sin_heading;
      logic signed [COORD_W-1:0] pose_x;
      logic signed [COORD_W-1:0] pose_y;
      logic [ROWS_W-1:0]         grid_rows;
      logic [ROWS_W-1:0]         grid_cols;
      logic                      pose_valid;
   } ptgm_cfg_type;

   typedef struct packed {
      logic base_we;
      logic base_re;
      logic mark_we;
      logic mark_clr;
      logic mark_re;
   } ptgm_mem_ctl_type;

endpackage

`default_nettype wire

// File: rtl/core/ptgm_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared signed multiplier with a registered product.
module ptgm_mul
   import ptgm_pkg::*;
(
   input  logic                      clock,
   input  logic signed [MUL_A_W-1:0] a,
   input  logic signed [MUL_B_W-1:0] b,
   output logic signed [MUL_P_W-1:0] p
);

   logic signed [MUL_P_W-1:0] p_ff;
   logic signed [MUL_P_W-1:0] p_in;

   always_comb begin
      p_in = a * b;
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign p = p_ff;

endmodule

`default_nettype wire

// File: rtl/core/ptgm_grid.sv
`timescale 1ns / 1ps
`default_nettype none

// Base map (one byte per cell) and mark grid (one bit per cell, one row per word).
module ptgm_grid
   import ptgm_pkg::*;
#(
   parameter int  GRID_SIZE = GRID_SIZE_DEF,
   localparam int NCELLS    = GRID_SIZE * GRID_SIZE,
   localparam int ADDR_W    = $clog2(NCELLS),
   localparam int ROW_W     = $clog2(GRID_SIZE)
) (
   input  logic                      clock,
   input  ptgm_mem_ctl_type          ctl,
   input  logic [ADDR_W-1:0]         base_addr,
   input  logic signed [VALUE_W-1:0] base_wdata,
   input  logic [ROW_W-1:0]          mark_row,
   input  logic [GRID_SIZE-1:0]      mark_mask,
   output logic signed [VALUE_W-1:0] base_rdata,
   output logic [GRID_SIZE-1:0]      mark_rdata
);

   logic signed [VALUE_W-1:0] base_mem_ff [NCELLS];
   logic [GRID_SIZE-1:0]      mark_mem_ff [GRID_SIZE];
   logic signed [VALUE_W-1:0] base_rdata_ff;
   logic [GRID_SIZE-1:0]      mark_rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.base_we) begin
         base_mem_ff[base_addr] <= base_wdata;
      end
      if (ctl.base_re) begin
         base_rdata_ff <= base_mem_ff[base_addr];
      end
   end

   // Marks only ever set bits, so a row is written with per-bit enables.
   always_ff @(posedge clock) begin
      if (ctl.mark_clr) begin
         mark_mem_ff[mark_row] <= '0;
      end else if (ctl.mark_we) begin
         for (int b = 0; b < GRID_SIZE; b++) begin
            if (mark_mask[b]) begin
               mark_mem_ff[mark_row][b] <= 1'b1;
            end
         end
      end
      if (ctl.mark_re) begin
         mark_rdata_ff <= mark_mem_ff[mark_row];
      end
   end

   assign base_rdata = base_rdata_ff;
   assign mark_rdata = mark_rdata_ff;

endmodule

`default_nettype wire

// File: rtl/core/ptgm_csr.sv
`timescale 1ns / 1ps
`default_nettype none

// Configuration registers behind a simple APB-style port.
module ptgm_csr
   import ptgm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output ptgm_cfg_type          cfg
);

   localparam logic [2:0] REG_COS_HEADING = 3'd0;
   localparam logic [2:0] REG_SIN_HEADING = 3'd1;
   localparam logic [2:0] REG_POSE_X      = 3'd2;
   localparam logic [2:0] REG_POSE_Y      = 3'd3;
   localparam logic [2:0] REG_GRID_ROWS   = 3'd4;
   localparam logic [2:0] REG_GRID_COLS   = 3'd5;
   localparam logic [2:0] REG_POSE_VALID  = 3'd6;

   ptgm_cfg_type cfg_ff;
   ptgm_cfg_type cfg_in;
   logic [2:0]   reg_index;
   logic         wr_en;

   assign reg_index = paddr[4:2];
   assign wr_en     = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            REG_COS_HEADING: cfg_in.cos_heading = pwdata[COORD_W-1:0];
            REG_SIN_HEADING: cfg_in.sin_heading = pwdata[COORD_W-1:0];
            REG_POSE_X:      cfg_in.pose_x      = pwdata[COORD_W-1:0];
            REG_POSE_Y:      cfg_in.pose_y      = pwdata[COORD_W-1:0];
            REG_GRID_ROWS:   cfg_in.grid_rows   = pwdata[ROWS_W-1:0];
            REG_GRID_COLS:   cfg_in.grid_cols   = pwdata[ROWS_W-1:0];
            REG_POSE_VALID:  cfg_in.pose_valid  = pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cos_heading <= 16'sd16384;
         cfg_ff.sin_heading <= '0;
         cfg_ff.pose_x      <= '0;
         cfg_ff.pose_y      <= '0;
         cfg_ff.grid_rows   <= 7'd96;
         cfg_ff.grid_cols   <= 7'd96;
         cfg_ff.pose_valid  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_index)
         REG_COS_HEADING: prdata = CSR_DATA_W'(unsigned'(cfg_ff.cos_heading));
         REG_SIN_HEADING: prdata = CSR_DATA_W'(unsigned'(cfg_ff.sin_heading));
         REG_POSE_X:      prdata = CSR_DATA_W'(unsigned'(cfg_ff.pose_x));
         REG_POSE_Y:      prdata = CSR_DATA_W'(unsigned'(cfg_ff.pose_y));
         REG_GRID_ROWS:   prdata = CSR_DATA_W'(cfg_ff.grid_rows);
         REG_GRID_COLS:   prdata = CSR_DATA_W'(cfg_ff.grid_cols);
         REG_POSE_VALID:  prdata = CSR_DATA_W'(cfg_ff.pose_valid);
         default:         prdata = '0;
      endcase
   end

   assign pready = 1'b1;
   assign cfg    = cfg_ff;

endmodule

`default_nettype wire

// File: rtl/core/point_to_grid_marker.sv
// A mark with a valid pose runs its rotation and scaling products on the multiplier and then
// writes the stamp rows; no request is taken until it is done. A load is written from the
// request while idle. A read splits the index and reads both stores, or for an index off the
// grid goes straight to the result state, which waits for a free response slot. All products
// use one shared multiplier, and the stamp writes one grid row a cycle. Reset (synchronous,
// active high) starts a pass that clears both stores; no request is accepted until it ends.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module point_to_grid_marker
   import ptgm_pkg::*;
#(
   parameter int GRID_SIZE       = GRID_SIZE_DEF,
   parameter int CELLS_PER_METER = CPM_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // Request channel.
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [FUNC_W-1:0]         req_func,
   input  logic signed [COORD_W-1:0] req_point_x,
   input  logic signed [COORD_W-1:0] req_point_y,
   input  logic [CELL_INDEX_W-1:0]   req_cell_index,
   input  logic signed [VALUE_W-1:0] req_cell_value,
   // Response channel.
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [VALUE_W-1:0] rsp_merged_value,
   // Configuration port.
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [CSR_DATA_W-1:0]     csr_pwdata,
   output logic [CSR_DATA_W-1:0]     csr_prdata,
   output logic                      csr_pready
);

   localparam int NCELLS    = GRID_SIZE * GRID_SIZE;
   localparam int ADDR_W    = $clog2(NCELLS);
   localparam int ROW_W     = $clog2(GRID_SIZE);
   localparam int IDX_EXT_W = ((ADDR_W > CELL_INDEX_W) ? ADDR_W : CELL_INDEX_W) + 1;
   // Reciprocal of the grid size scaled by 2^ADDR_W. The quotient it gives is at most one
   // below the true row, which a single compare and subtract then fixes.
   localparam int RECIP     = (1 << ADDR_W) / GRID_SIZE;
   localparam int RND_HALF  = 1 << (RND_SHIFT - 1);

   // Step numbers of the mark schedule on the shared multiplier.
   localparam logic [2:0] SP_COS_PX  = 3'd0;
   localparam logic [2:0] SP_SIN_PY  = 3'd1;
   localparam logic [2:0] SP_SIN_PX  = 3'd2;
   localparam logic [2:0] SP_COS_PY  = 3'd3;
   localparam logic [2:0] SP_SCALE_X = 3'd4;
   localparam logic [2:0] SP_SCALE_Y = 3'd5;
   localparam logic [2:0] SP_ROUND_Y = 3'd6;
   // Step numbers of the index-to-row/column split.
   localparam logic [2:0] SD_RECIP   = 3'd0;
   localparam logic [2:0] SD_BACK    = 3'd1;
   localparam logic [2:0] SD_FIX     = 3'd2;
   // The stamp covers three rows.
   localparam logic [2:0] ROW_LAST   = 3'd2;

   ptgm_cfg_type     cfg;
   ptgm_mem_ctl_type mem_ctl;

   ptgm_state_type state_ff, state_in;
   logic [2:0]     step_ff, step_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic           rsp_valid_ff, rsp_valid_in;

   logic signed [COORD_W-1:0] px_ff, px_in;
   logic signed [COORD_W-1:0] py_ff, py_in;
   logic [ADDR_W-1:0]         idx_ff, idx_in;
   logic                      oob_ff, oob_in;
   logic signed [MUL_A_W-1:0] acc_x_ff, acc_x_in;
   logic signed [MUL_A_W-1:0] acc_y_ff, acc_y_in;
   logic signed [CELL_W-1:0]  m_ff, m_in;
   logic signed [CELL_W-1:0]  n_ff, n_in;
   logic [ROW_W-1:0]          row_ff, row_in;
   logic [ROW_W-1:0]          col_ff, col_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;

   logic                      accept;
   logic                      slot_free;
   logic                      clr_last;
   logic [IDX_EXT_W-1:0]      idx_ext;
   logic                      idx_ok;
   logic [ADDR_W-1:0]         idx_req;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] mul_p;

   logic signed [MUL_A_W-1:0] pose_x_term;
   logic signed [MUL_A_W-1:0] pose_y_term;
   logic signed [RND_W-1:0]   rnd_sum;
   logic signed [CELL_W-1:0]  cell_rnd;
   logic [ROW_W-1:0]          q_est;
   logic [ADDR_W-1:0]         div_rem;
   logic [ROW_W:0]            rem_low;

   logic signed [CELL_W-1:0]  rlim;
   logic signed [CELL_W-1:0]  clim;
   logic signed [CELL_W-1:0]  row_i;
   logic                      row_ok;
   logic [GRID_SIZE-1:0]      col_mask;

   logic [ADDR_W-1:0]         base_addr;
   logic signed [VALUE_W-1:0] base_wdata;
   logic [ROW_W-1:0]          mark_row;
   logic [GRID_SIZE-1:0]      mark_mask;
   logic signed [VALUE_W-1:0] base_rdata;
   logic [GRID_SIZE-1:0]      mark_rdata;
   logic signed [VALUE_W:0]   merged_sum;
   logic signed [VALUE_W-1:0] merged;

   ptgm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   ptgm_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p     (mul_p)
   );

   ptgm_grid #(
      .GRID_SIZE (GRID_SIZE)
   ) u_grid (
      .clock      (clock),
      .ctl        (mem_ctl),
      .base_addr  (base_addr),
      .base_wdata (base_wdata),
      .mark_row   (mark_row),
      .mark_mask  (mark_mask),
      .base_rdata (base_rdata),
      .mark_rdata (mark_rdata)
   );

   // ------------------------------------------------------------------------------------
   // Shared decode. A request index is widened before the range check so that indexes the
   // port can carry but the grid does not hold are rejected rather than wrapped.
   // ------------------------------------------------------------------------------------
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign clr_last  = (clr_cnt_ff == ADDR_W'(NCELLS - 1));
   assign idx_ext   = IDX_EXT_W'(req_cell_index);
   assign idx_ok    = (idx_ext < IDX_EXT_W'(NCELLS));
   assign idx_req   = idx_ext[ADDR_W-1:0];

   // The robot position enters the rotated sum in the same Q.22 scale as the products.
   assign pose_x_term = MUL_A_W'(cfg.pose_x) <<< POSE_SHIFT;
   assign pose_y_term = MUL_A_W'(cfg.pose_y) <<< POSE_SHIFT;

   // Round to nearest with ties away from zero in one add: a negative value gets one less
   // than half a cell added before the arithmetic shift, which floors.
   assign rnd_sum  = mul_p[RND_W-1:0]
                   + (mul_p[MUL_P_W-1] ? RND_W'(RND_HALF - 1) : RND_W'(RND_HALF));
   assign cell_rnd = rnd_sum[RND_W-1:RND_SHIFT];

   // Index split: estimated row, then the remainder against it.
   assign q_est   = mul_p[ADDR_W+ROW_W-1:ADDR_W];
   assign div_rem = idx_ff - mul_p[ADDR_W-1:0];
   assign rem_low = div_rem[ROW_W:0];

   // Bounds of the stamp. Configured sizes above the grid act as the grid size.
   always_comb begin
      if (CELL_W'(cfg.grid_rows) > CELL_W'(GRID_SIZE)) begin
         rlim = CELL_W'(GRID_SIZE);
      end else begin
         rlim = CELL_W'(cfg.grid_rows);
      end
      if (CELL_W'(cfg.grid_cols) > CELL_W'(GRID_SIZE)) begin
         clim = CELL_W'(GRID_SIZE);
      end else begin
         clim = CELL_W'(cfg.grid_cols);
      end
   end

   assign row_i  = m_ff - CELL_W'(1) + CELL_W'(step_ff);
   assign row_ok = !row_i[CELL_W-1] && (row_i < rlim);

   // Column mask of the stamp: up to three neighboring columns inside the used width.
   always_comb begin
      logic signed [CELL_W-1:0] col_pos;
      logic signed [CELL_W-1:0] n_lo;
      logic signed [CELL_W-1:0] n_hi;
      n_lo = n_ff - CELL_W'(1);
      n_hi = n_ff + CELL_W'(1);
      col_pos = '0;
      for (int b = 0; b < GRID_SIZE; b++) begin
         col_pos = CELL_W'(b);
         col_mask[b] = (col_pos >= n_lo) && (col_pos <= n_hi) && (col_pos < clim);
      end
   end

   // Merge on read: base value plus the mark bit, saturated at the top of the byte range.
   assign merged_sum = {base_rdata[VALUE_W-1], base_rdata}
                     + (VALUE_W + 1)'(mark_rdata[col_ff]);
   assign merged     = (merged_sum == (VALUE_W + 1)'(128)) ? VALUE_W'(127)
                                                           : merged_sum[VALUE_W-1:0];

   // ------------------------------------------------------------------------------------
   // Sequencer next state.
   // ------------------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (req_func)
                  FUNC_MARK: begin
                     if (cfg.pose_valid) begin
                        state_in = ST_MARK_MUL;
                     end
                  end
                  FUNC_READ: begin
                     state_in = idx_ok ? ST_READ_DIV : ST_RESULT;
                  end
                  default: ;
               endcase
            end
         end
         ST_MARK_MUL: begin
            if (step_ff == SP_ROUND_Y) begin
               state_in = ST_MARK_ROW;
            end
         end
         ST_MARK_ROW: begin
            if (step_ff == ROW_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ_DIV: begin
            if (step_ff == SD_FIX) begin
               state_in = ST_READ_MEM;
            end
         end
         ST_READ_MEM: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------------------------
   // Sequencer outputs: handshake, memory control and the multiplier operand select.
   // ------------------------------------------------------------------------------------
   always_comb begin
      req_ready  = 1'b0;
      mem_ctl    = '0;
      base_addr  = idx_ff;
      base_wdata = req_cell_value;
      mark_row   = row_ff;
      mark_mask  = col_mask;
      mul_a      = '0;
      mul_b      = '0;
      case (state_ff)
         ST_CLEAR: begin
            // One base cell per cycle; the mark rows are cleared while the counter is below GRID_SIZE.
            mem_ctl.base_we  = 1'b1;
            mem_ctl.mark_clr = (clr_cnt_ff < ADDR_W'(GRID_SIZE));
            base_addr        = clr_cnt_ff;
            base_wdata       = '0;
            mark_row         = clr_cnt_ff[ROW_W-1:0];
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            // A load is written straight from the request.
            if (req_valid && (req_func == FUNC_LOAD) && idx_ok) begin
               mem_ctl.base_we = 1'b1;
               base_addr       = idx_req;
            end
         end
         ST_MARK_MUL: begin
            case (step_ff)
               SP_COS_PX: begin
                  mul_a = MUL_A_W'(cfg.cos_heading);
                  mul_b = MUL_B_W'(px_ff);
               end
               SP_SIN_PY: begin
                  mul_a = MUL_A_W'(cfg.sin_heading);
                  mul_b = MUL_B_W'(py_ff);
               end
               SP_SIN_PX: begin
                  mul_a = MUL_A_W'(cfg.sin_heading);
                  mul_b = MUL_B_W'(px_ff);
               end
               SP_COS_PY: begin
                  mul_a = MUL_A_W'(cfg.cos_heading);
                  mul_b = MUL_B_W'(py_ff);
               end
               SP_SCALE_X: begin
                  mul_a = acc_x_ff;
                  mul_b = MUL_B_W'(CELLS_PER_METER);
               end
               SP_SCALE_Y: begin
                  mul_a = acc_y_ff;
                  mul_b = MUL_B_W'(CELLS_PER_METER);
               end
               default: ;
            endcase
         end
         ST_MARK_ROW: begin
            mem_ctl.mark_we = row_ok;
            mark_row        = row_i[ROW_W-1:0];
         end
         ST_READ_DIV: begin
            case (step_ff)
               SD_RECIP: begin
                  mul_a = MUL_A_W'(idx_ff);
                  mul_b = MUL_B_W'(RECIP);
               end
               SD_BACK: begin
                  mul_a = MUL_A_W'(q_est);
                  mul_b = MUL_B_W'(GRID_SIZE);
               end
               default: ;
            endcase
         end
         ST_READ_MEM: begin
            mem_ctl.base_re = 1'b1;
            mem_ctl.mark_re = 1'b1;
         end
         default: ;
      endcase
   end

   // ------------------------------------------------------------------------------------
   // Datapath next values.
   // ------------------------------------------------------------------------------------
   always_comb begin
      step_in      = '0;
      clr_cnt_in   = clr_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      px_in        = px_ff;
      py_in        = py_ff;
      idx_in       = idx_ff;
      oob_in       = oob_ff;
      acc_x_in     = acc_x_ff;
      acc_y_in     = acc_y_ff;
      m_in         = m_ff;
      n_in         = n_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      rsp_value_in = rsp_value_ff;

      if (state_in == state_ff) begin
         case (state_ff)
            ST_MARK_MUL, ST_MARK_ROW, ST_READ_DIV: step_in = step_ff + 3'd1;
            default: step_in = '0;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               px_in  = req_point_x;
               py_in  = req_point_y;
               idx_in = idx_req;
               oob_in = !idx_ok;
            end
         end
         ST_MARK_MUL: begin
            // Each product is read in the step after the one that issued its operands.
            case (step_ff)
               SP_SIN_PY:  acc_x_in = pose_x_term + mul_p[MUL_A_W-1:0];
               SP_SIN_PX:  acc_x_in = acc_x_ff - mul_p[MUL_A_W-1:0];
               SP_COS_PY:  acc_y_in = pose_y_term + mul_p[MUL_A_W-1:0];
               SP_SCALE_X: acc_y_in = acc_y_ff + mul_p[MUL_A_W-1:0];
               SP_SCALE_Y: m_in     = cell_rnd;
               SP_ROUND_Y: n_in     = cell_rnd;
               default: ;
            endcase
         end
         ST_READ_DIV: begin
            case (step_ff)
               SD_BACK: begin
                  row_in = q_est;
               end
               SD_FIX: begin
                  if (rem_low >= (ROW_W + 1)'(GRID_SIZE)) begin
                     row_in = row_ff + ROW_W'(1);
                     col_in = ROW_W'(rem_low - (ROW_W + 1)'(GRID_SIZE));
                  end else begin
                     col_in = rem_low[ROW_W-1:0];
                  end
               end
               default: ;
            endcase
         end
         ST_RESULT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = oob_ff ? '0 : merged;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         step_ff      <= '0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff        <= px_in;
      py_ff        <= py_in;
      idx_ff       <= idx_in;
      oob_ff       <= oob_in;
      acc_x_ff     <= acc_x_in;
      acc_y_ff     <= acc_y_in;
      m_ff         <= m_in;
      n_ff         <= n_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_merged_value = rsp_value_ff;

   // ------------------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------------------
   // A response appears only out of the result state.
   `ASSERT_PROP(a_rsp_from_result, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff) == ST_RESULT)
   // The clearing pass runs once after reset and is never entered again.
   `ASSERT_PROP(a_clear_once, clock, reset, (!$past(reset) && ($past(state_ff) != ST_CLEAR)) |-> (state_ff != ST_CLEAR))
   // The row and column split rebuilds the request index exactly.
   `ASSERT_PROP(a_split_exact, clock, reset, (state_ff == ST_READ_MEM) |-> ((ADDR_W'(row_ff) * ADDR_W'(GRID_SIZE) + ADDR_W'(col_ff)) == idx_ff) && (col_ff < ROW_W'(GRID_SIZE)))
   // Stamp writes stay on the grid.
   `ASSERT_PROP(a_mark_on_grid, clock, reset, mem_ctl.mark_we |-> (state_ff == ST_MARK_ROW) && (mark_row < ROW_W'(GRID_SIZE)))

endmodule

`default_nettype wire
